// File: sv/four_voice_synth_with_svf_assert.svh
// Assertion helpers for the RTL modules, included by fvs_ctrl.
`ifndef FOUR_VOICE_SYNTH_WITH_SVF_ASSERT_SVH
`define FOUR_VOICE_SYNTH_WITH_SVF_ASSERT_SVH

// Check a consequence in the same cycle.
`define FVS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define FVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fvs_pkg.sv
`default_nettype none
package fvs_pkg;

  localparam logic [27:0] PHASE_HALF  = 28'h8000000;
  localparam logic [23:0] LEVEL_MAX   = 24'hffffff;
  localparam logic [23:0] SUSTAIN_UNIT = 24'h111111;
  localparam logic [22:0] LFSR_SEED   = 23'h7ffff8;
  localparam logic [8:0]  FREQ_STEP   = 9'd359;
  localparam int          DIV_STEPS   = 25;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_VOICE  = 2'd1,
    REQ_GLOBAL = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ENV_RELEASE = 2'd0,
    ENV_ATTACK  = 2'd1,
    ENV_DECAY   = 2'd2,
    ENV_SUSTAIN = 2'd3
  } env_phase_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_VWR, OP_GWR, OP_START, OP_FC, OP_FP, OP_PH, OP_MUL0, OP_MUL1,
    OP_DIV, OP_UPD, OP_SCALE, OP_ACC, OP_F1, OP_F2, OP_F3, OP_F4, OP_F5, OP_F6,
    OP_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_FC, S_FP, S_PH, S_MUL0, S_MUL1, S_DIV, S_UPD, S_SCALE, S_ACC,
    S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } fvs_cmd_t;

  typedef struct packed {
    logic sync;
    logic div_done;
    logic last_voice;
    logic out_free;
  } fvs_status_t;

  function automatic logic [23:0] attack_rate(input logic [3:0] idx);
    logic [23:0] r;
    case (idx)
      4'd0:  r = 24'd168867;
      4'd1:  r = 24'd47495;
      4'd2:  r = 24'd24124;
      4'd3:  r = 24'd15998;
      4'd4:  r = 24'd10200;
      4'd5:  r = 24'd6908;
      4'd6:  r = 24'd5692;
      4'd7:  r = 24'd4855;
      4'd8:  r = 24'd3877;
      4'd9:  r = 24'd1555;
      4'd10: r = 24'd777;
      4'd11: r = 24'd486;
      4'd12: r = 24'd389;
      4'd13: r = 24'd129;
      4'd14: r = 24'd77;
      default: r = 24'd48;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] release_rate(input logic [3:0] idx);
    logic [23:0] r;
    case (idx)
      4'd0:  r = 24'd42660;
      4'd1:  r = 24'd15468;
      4'd2:  r = 24'd7857;
      4'd3:  r = 24'd5210;
      4'd4:  r = 24'd3322;
      4'd5:  r = 24'd2250;
      4'd6:  r = 24'd1853;
      4'd7:  r = 24'd1581;
      4'd8:  r = 24'd1262;
      4'd9:  r = 24'd506;
      4'd10: r = 24'd253;
      4'd11: r = 24'd158;
      4'd12: r = 24'd126;
      4'd13: r = 24'd42;
      4'd14: r = 24'd25;
      default: r = 24'd15;
    endcase
    return r;
  endfunction

  function automatic logic [14:0] damping(input logic [3:0] k);
    logic [14:0] r;
    case (k)
      4'd0:  r = 15'd19661;
      4'd1:  r = 15'd19005;
      4'd2:  r = 15'd18350;
      4'd3:  r = 15'd17695;
      4'd4:  r = 15'd17039;
      4'd5:  r = 15'd16384;
      4'd6:  r = 15'd15729;
      4'd7:  r = 15'd15073;
      4'd8:  r = 15'd14418;
      4'd9:  r = 15'd13763;
      4'd10: r = 15'd13107;
      4'd11: r = 15'd12452;
      4'd12: r = 15'd11796;
      4'd13: r = 15'd11141;
      4'd14: r = 15'd10486;
      default: r = 15'd9830;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/four_voice_synth_with_svf.sv
`default_nettype none
// Four-voice synthesizer with a state-variable filter behind byte registers.
// s_axis_tuser carries the request kind (tick, voice write, global write);
// a write returns nothing, a tick returns one word. A tick runs the serial
// voice loop, and the one-bit-per-cycle sync divider for every voice that
// hard-syncs on that tick. A finished word waits in the output register
// while the next request is taken.
module four_voice_synth_with_svf #(
  parameter int VOICES = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // voice[1:0], reg_index[4:2], write_value[12:5], zero[15:13]
  input  logic [15:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sample[15:0], level_voice0[39:16], level_voice1[63:40],
  // level_voice2[87:64], level_voice3[111:88]
  output logic [111:0] m_axis_tdata
);
  import fvs_pkg::*;

  fvs_cmd_t    cmd;
  fvs_status_t status;
  logic [15:0] sample;
  logic [23:0] level [4];

  fvs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_kind_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  fvs_datapath #(
    .VOICES (VOICES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_voice_i (s_axis_tdata[1:0]),
    .in_reg_i   (s_axis_tdata[4:2]),
    .in_value_i (s_axis_tdata[12:5]),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .sample_o   (sample),
    .level_o    (level)
  );

  assign m_axis_tdata = {level[3], level[2], level[1], level[0], sample};

endmodule
`default_nettype wire

// File: sv/fvs_ctrl.sv
`default_nettype none
`include "four_voice_synth_with_svf_assert.svh"
module fvs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic [1:0]            s_kind_i,
  output logic                  s_ready_o,
  input  fvs_pkg::fvs_status_t  status_i,
  output fvs_pkg::fvs_cmd_t     cmd_o
);
  import fvs_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        fire;

  assign s_ready_o = (state_q == S_IDLE);
  assign fire      = s_valid_i && s_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (fire && s_kind_i == REQ_TICK) state_d = S_FC;
      end
      S_FC:    state_d = S_FP;
      S_FP:    state_d = S_PH;
      S_PH:    state_d = status_i.sync ? S_MUL0 : S_UPD;
      S_MUL0:  state_d = S_MUL1;
      S_MUL1:  state_d = S_DIV;
      S_DIV:   state_d = status_i.div_done ? S_UPD : S_DIV;
      S_UPD:   state_d = S_SCALE;
      S_SCALE: state_d = S_ACC;
      S_ACC:   state_d = status_i.last_voice ? S_F1 : S_FC;
      S_F1:    state_d = S_F2;
      S_F2:    state_d = S_F3;
      S_F3:    state_d = S_F4;
      S_F4:    state_d = S_F5;
      S_F5:    state_d = S_F6;
      S_F6:    state_d = S_OUT;
      S_OUT:   state_d = status_i.out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          unique case (s_kind_i)
            REQ_TICK:   cmd_o.op = OP_START;
            REQ_VOICE:  cmd_o.op = OP_VWR;
            REQ_GLOBAL: cmd_o.op = OP_GWR;
            default:    cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_FC:    cmd_o.op = OP_FC;
      S_FP:    cmd_o.op = OP_FP;
      S_PH:    cmd_o.op = OP_PH;
      S_MUL0:  cmd_o.op = OP_MUL0;
      S_MUL1:  cmd_o.op = OP_MUL1;
      S_DIV:   cmd_o.op = OP_DIV;
      S_UPD:   cmd_o.op = OP_UPD;
      S_SCALE: cmd_o.op = OP_SCALE;
      S_ACC:   cmd_o.op = OP_ACC;
      S_F1:    cmd_o.op = OP_F1;
      S_F2:    cmd_o.op = OP_F2;
      S_F3:    cmd_o.op = OP_F3;
      S_F4:    cmd_o.op = OP_F4;
      S_F5:    cmd_o.op = OP_F5;
      S_F6:    cmd_o.op = OP_F6;
      S_OUT:   cmd_o.op = status_i.out_free ? OP_OUT : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  `FVS_ASSERT_NEXT(a_tick_starts, fire && s_kind_i == REQ_TICK, state_q == S_FC, "tick lost")
  `FVS_ASSERT_NEXT(a_div_exit, state_q == S_DIV && status_i.div_done, state_q == S_UPD,
                   "divider exit missed")
  `FVS_ASSERT_NEXT(a_out_hold, state_q == S_OUT && !status_i.out_free, state_q == S_OUT,
                   "result dropped while stalled")

endmodule
`default_nettype wire

// File: sv/fvs_datapath.sv
`default_nettype none
module fvs_datapath #(
  parameter int VOICES = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fvs_pkg::fvs_cmd_t    cmd_i,
  output fvs_pkg::fvs_status_t status_o,
  input  logic [1:0]           in_voice_i,
  input  logic [2:0]           in_reg_i,
  input  logic [7:0]           in_value_i,
  input  logic                 m_ready_i,
  output logic                 m_valid_o,
  output logic [15:0]          sample_o,
  output logic [23:0]          level_o [4]
);
  import fvs_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic [15:0]  freq_q  [VOICES];
  logic [11:0]  pw_q    [VOICES];
  logic [7:0]   flags_q [VOICES];
  logic [7:0]   ad_q    [VOICES];
  logic [7:0]   sr_q    [VOICES];
  logic [VOICES-1:0] ad_vld_q, sr_vld_q, route_q;
  logic [27:0]  phase_q [VOICES];
  env_phase_e   eph_q   [VOICES];
  logic [23:0]  lvl_q   [VOICES];
  logic [11:0]  apw_q   [VOICES];
  logic [22:0]  lfsr_q  [VOICES];
  logic [4:0]   nstep_q [VOICES];
  logic [7:0]   nval_q  [VOICES];

  logic [2:0]   g0_q;
  logic [7:0]   g1_q;
  logic [16:0]  coef_q;
  logic [14:0]  damp_q;
  logic [2:0]   mode_q;
  logic signed [31:0] lo_q, bd_q, hi_q;

  logic [VW-1:0] c_q, p_v, rd_v, wv;
  logic [24:0]  fc_q, fp_q, rem_q, dq_q;
  logic [27:0]  phc_q, pp_q, ph_q;
  logic         sync_q;
  logic [37:0]  prod_q;
  logic [4:0]   cnt_q;
  logic [7:0]   w_q;
  logic signed [15:0] scl_q;
  logic signed [19:0] acc0_q, acc1_q;
  logic signed [47:0] m1_q;
  logic signed [49:0] m2_q;
  logic         m_valid_q;
  logic [15:0]  sample_q;
  logic [23:0]  lvl_out_q [4];

  logic         v_ok;
  logic [24:0]  step_rd;
  logic [36:0]  mhi;
  logic [49:0]  sum50;
  logic [25:0]  r2, diff;
  logic         ge;
  logic [27:0]  ph_f, rp;
  logic [7:0]   fl;
  logic         gate;
  env_phase_e   eph_in, eph_n;
  logic [23:0]  atk, dec, sus, rel;
  logic signed [25:0] lv, nlv, susv, lvl_n;
  logic [11:0]  apw_n;
  logic [27:0]  tri_src;
  logic [7:0]   tri_w, saw_w, pulse_w, nval_n, w_n;
  logic [22:0]  sr_n, lfsr_n;
  logic         nclk;
  logic [10:0]  ff_n;
  logic signed [33:0] sprod;
  logic signed [39:0] hi_sum, bd_sum, lo_sum;
  logic signed [34:0] fsum, fadj;
  logic signed [26:0] fq;
  logic signed [35:0] s_sum;
  logic [15:0]  s_clamp;

  assign p_v  = (c_q == '0) ? VW'(VOICES - 1) : c_q - 1'b1;
  assign rd_v = (cmd_i.op == OP_FP) ? p_v : c_q;
  assign wv   = VW'(in_voice_i);
  assign v_ok = (32'(in_voice_i) < VOICES);

  assign step_rd = {9'd0, freq_q[rd_v]} * {16'd0, FREQ_STEP};

  assign mhi   = 37'(pp_q[24:0]) * 37'(fc_q[24:13]);
  assign sum50 = 50'(prod_q) + {mhi, 13'd0};
  assign r2    = {rem_q, dq_q[24]};
  assign diff  = r2 - {1'b0, fp_q};
  assign ge    = (r2 >= {1'b0, fp_q});

  assign status_o.sync       = flags_q[c_q][1] && (pp_q < {3'd0, fp_q});
  assign status_o.div_done   = (cnt_q == 5'(DIV_STEPS - 1));
  assign status_o.last_voice = (c_q == VW'(VOICES - 1));
  assign status_o.out_free   = !m_valid_q || m_ready_i;

  always_comb begin
    ph_f = sync_q ? {3'd0, dq_q} : ph_q;
    rp   = (VOICES == 1) ? ph_f : pp_q;
    fl   = flags_q[c_q];
    gate = fl[0];
    eph_in = eph_q[c_q];
    if (gate && eph_in == ENV_RELEASE) eph_in = ENV_ATTACK;
    if (!gate) eph_in = ENV_RELEASE;
    atk  = ad_vld_q[c_q] ? attack_rate(ad_q[c_q][7:4]) : 24'd0;
    dec  = ad_vld_q[c_q] ? release_rate(ad_q[c_q][3:0]) : 24'd0;
    sus  = sr_vld_q[c_q] ? 24'({20'd0, sr_q[c_q][7:4]} * SUSTAIN_UNIT) : 24'd0;
    rel  = sr_vld_q[c_q] ? release_rate(sr_q[c_q][3:0]) : 24'd0;
    lv   = $signed({2'b00, lvl_q[c_q]});
    susv = $signed({2'b00, sus});
    lvl_n = lv;
    eph_n = eph_in;
    nlv   = lv;
    case (eph_in)
      ENV_ATTACK: begin
        nlv = lv + $signed({2'b00, atk});
        if (nlv >= $signed({2'b00, LEVEL_MAX})) begin
          lvl_n = $signed({2'b00, LEVEL_MAX});
          eph_n = ENV_DECAY;
        end else begin
          lvl_n = nlv;
        end
      end
      ENV_DECAY: begin
        nlv = lv - $signed({2'b00, dec});
        if (nlv <= susv) begin
          lvl_n = susv;
          eph_n = ENV_SUSTAIN;
        end else begin
          lvl_n = nlv;
        end
      end
      ENV_SUSTAIN: begin
        if (lv != susv) eph_n = ENV_ATTACK;
      end
      ENV_RELEASE: begin
        nlv = lv - $signed({2'b00, rel});
        lvl_n = (nlv < 0) ? 26'sd0 : nlv;
      end
      default: lvl_n = lv;
    endcase

    apw_n   = (ph_f < {3'd0, fc_q}) ? pw_q[c_q] : apw_q[c_q];
    tri_src = (ph_f < PHASE_HALF) ? ph_f : ~ph_f;
    tri_w   = tri_src[26:19];
    saw_w   = ph_f[27:20];
    pulse_w = (ph_f > {apw_n, 16'd0}) ? 8'h00 : 8'hff;
    nclk    = (ph_f[27:23] != nstep_q[c_q]);
    sr_n    = {lfsr_q[c_q][21:0], lfsr_q[c_q][22] ^ lfsr_q[c_q][17]};
    lfsr_n  = nclk ? sr_n : lfsr_q[c_q];
    nval_n  = nclk ? {sr_n[22], sr_n[20], sr_n[16], sr_n[13],
                      sr_n[11], sr_n[7], sr_n[4], sr_n[2]} : nval_q[c_q];
    if (fl[2] && rp < PHASE_HALF) tri_w = ~tri_w;
    w_n = 8'hff;
    if (fl[4]) w_n = w_n & tri_w;
    if (fl[5]) w_n = w_n & saw_w;
    if (fl[6]) w_n = w_n & pulse_w;
    if (fl[7]) w_n = w_n & nval_n;
  end

  assign ff_n  = (in_reg_i == 3'd0) ? {g1_q, in_value_i[2:0]} : {in_value_i, g0_q};
  assign sprod = ($signed({1'b0, w_q}) - 10'sd128) * $signed({1'b0, lvl_q[c_q]});

  assign hi_sum = (40'(acc1_q) <<< 8) - 40'(m1_q >>> 14) - 40'(lo_q);
  assign bd_sum = 40'(bd_q) + 40'(m2_q >>> 16);
  assign lo_sum = 40'(lo_q) + 40'(m2_q >>> 16);

  always_comb begin
    fsum = '0;
    if (mode_q[0]) fsum = fsum + 35'(lo_q);
    if (mode_q[1]) fsum = fsum + 35'(bd_q);
    if (mode_q[2]) fsum = fsum + 35'(hi_q);
    fadj  = (fsum < 0) ? fsum + 35'sd255 : fsum;
    fq    = 27'(fadj >>> 8);
    s_sum = 36'(acc0_q) + 36'(fq);
    if (s_sum > 36'sd32767) begin
      s_clamp = 16'h7fff;
    end else if (s_sum < -36'sd32768) begin
      s_clamp = 16'h8000;
    end else begin
      s_clamp = s_sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        freq_q[i]  <= '0;
        pw_q[i]    <= '0;
        flags_q[i] <= '0;
        ad_q[i]    <= '0;
        sr_q[i]    <= '0;
        phase_q[i] <= '0;
        eph_q[i]   <= ENV_RELEASE;
        lvl_q[i]   <= '0;
        apw_q[i]   <= '0;
        lfsr_q[i]  <= LFSR_SEED;
        nstep_q[i] <= '0;
        nval_q[i]  <= '0;
      end
      ad_vld_q  <= '0;
      sr_vld_q  <= '0;
      route_q   <= '0;
      g0_q      <= '0;
      g1_q      <= '0;
      coef_q    <= '0;
      damp_q    <= '0;
      mode_q    <= '0;
      lo_q      <= '0;
      bd_q      <= '0;
      hi_q      <= '0;
      c_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_VWR: begin
          if (v_ok) begin
            case (in_reg_i)
              3'd0: freq_q[wv][7:0]  <= in_value_i;
              3'd1: freq_q[wv][15:8] <= in_value_i;
              3'd2: pw_q[wv][7:0]    <= in_value_i;
              3'd3: pw_q[wv][11:8]   <= in_value_i[3:0];
              3'd4: flags_q[wv]      <= in_value_i;
              3'd5: begin
                ad_q[wv]     <= in_value_i;
                ad_vld_q[wv] <= 1'b1;
              end
              3'd6: begin
                sr_q[wv]     <= in_value_i;
                sr_vld_q[wv] <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        OP_GWR: begin
          case (in_reg_i)
            3'd0, 3'd1: begin
              if (in_reg_i == 3'd0) g0_q <= in_value_i[2:0];
              else g1_q <= in_value_i;
              coef_q <= {1'b0, ff_n, 5'd0};
            end
            3'd2: begin
              damp_q  <= damping(in_value_i[7:4]);
              route_q <= in_value_i[VOICES-1:0];
            end
            3'd3: mode_q <= in_value_i[6:4];
            default: ;
          endcase
        end
        OP_START: c_q <= '0;
        OP_UPD: begin
          phase_q[c_q] <= ph_f;
          eph_q[c_q]   <= eph_n;
          lvl_q[c_q]   <= lvl_n[23:0];
          apw_q[c_q]   <= apw_n;
          lfsr_q[c_q]  <= lfsr_n;
          nstep_q[c_q] <= ph_f[27:23];
          nval_q[c_q]  <= nval_n;
        end
        OP_ACC: begin
          if (!status_o.last_voice) c_q <= c_q + 1'b1;
        end
        OP_F2: hi_q <= sat32(hi_sum);
        OP_F4: bd_q <= sat32(bd_sum);
        OP_F6: lo_q <= sat32(lo_sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        acc0_q <= '0;
        acc1_q <= '0;
      end
      OP_FC: begin
        fc_q  <= step_rd;
        phc_q <= phase_q[rd_v];
      end
      OP_FP: begin
        fp_q <= step_rd;
        pp_q <= phase_q[rd_v];
      end
      OP_PH: begin
        ph_q   <= phc_q + {3'd0, fc_q};
        sync_q <= status_o.sync;
      end
      OP_MUL0: prod_q <= 38'(pp_q[24:0]) * 38'(fc_q[12:0]);
      OP_MUL1: begin
        rem_q <= sum50[49:25];
        dq_q  <= sum50[24:0];
        cnt_q <= '0;
      end
      OP_DIV: begin
        rem_q <= ge ? diff[24:0] : r2[24:0];
        dq_q  <= {dq_q[23:0], ge};
        cnt_q <= cnt_q + 5'd1;
      end
      OP_UPD: w_q <= w_n;
      OP_SCALE: scl_q <= 16'(sprod >>> 18);
      OP_ACC: begin
        if (route_q[c_q]) acc1_q <= acc1_q + 20'(scl_q);
        else acc0_q <= acc0_q + 20'(scl_q);
      end
      OP_F1: m1_q <= bd_q * $signed({1'b0, damp_q});
      OP_F3: m2_q <= $signed({1'b0, coef_q}) * hi_q;
      OP_F5: m2_q <= $signed({1'b0, coef_q}) * bd_q;
      OP_OUT: sample_q <= s_clamp;
      default: ;
    endcase
  end

  for (genvar i = 0; i < 4; i++) begin : g_lvl
    if (i < VOICES) begin : g_on
      always_ff @(posedge clk_i) begin
        if (cmd_i.op == OP_OUT) lvl_out_q[i] <= lvl_q[i];
      end
    end else begin : g_off
      assign lvl_out_q[i] = '0;
    end
    assign level_o[i] = lvl_out_q[i];
  end

  assign m_valid_o = m_valid_q;
  assign sample_o  = sample_q;

endmodule
`default_nettype wire
